### hw/rtl/clsrng_pkg.sv
`timescale 1ns / 1ps

package clsrng_pkg;

    localparam logic [31:0] MOD1     = 32'd2147483563;
    localparam logic [31:0] MOD2     = 32'd2147483399;
    localparam logic [15:0] MUL1     = 16'd40014;
    localparam logic [15:0] MUL2     = 16'd40692;
    localparam logic [7:0]  FOLD1    = 8'd85;
    localparam logic [7:0]  FOLD2    = 8'd249;
    localparam logic [31:0] WRAP_TOP = 32'd2147483562;
    localparam logic [30:0] G1_RESET = 31'd1;
    localparam logic [30:0] G2_RESET = 31'd123456789;

    localparam int VAL_W  = 31;
    localparam int PROD_W = VAL_W + 16;
    localparam int PC_W   = 4;

    localparam logic [1:0] JC_NEXT   = 2'd0;
    localparam logic [1:0] JC_JUMP   = 2'd1;
    localparam logic [1:0] JC_ACCEPT = 2'd2;
    localparam logic [1:0] JC_LOOP   = 2'd3;

    localparam logic [PC_W-1:0] A_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] A_WARM0 = 4'd1;
    localparam logic [PC_W-1:0] A_WARM1 = 4'd2;
    localparam logic [PC_W-1:0] A_WARM2 = 4'd3;
    localparam logic [PC_W-1:0] A_PRIME = 4'd4;
    localparam logic [PC_W-1:0] A_DRAW0 = 4'd5;
    localparam logic [PC_W-1:0] A_DRAW1 = 4'd6;
    localparam logic [PC_W-1:0] A_DRAW2 = 4'd7;
    localparam logic [PC_W-1:0] A_DRAW3 = 4'd8;

    typedef struct packed {
        logic            in_rdy;
        logic            step_g1;
        logic            step_g2;
        logic            wr_cnt;
        logic            wr_slot;
        logic            prev_g1;
        logic            prev_mix;
        logic            out_load;
        logic            dec_cnt;
        logic            wait_out;
        logic [1:0]      jc;
        logic [PC_W-1:0] tgt;
    } t_uword;

    typedef struct packed {
        logic load_seed;
        logic step_g1;
        logic step_g2;
        logic wr_en;
        logic wr_slot;
        logic prev_g1;
        logic prev_mix;
        logic out_load;
    } t_dp_ctl;

    typedef struct packed {
        logic out_busy;
    } t_dp_sts;

    function automatic t_uword f_urom(input logic [PC_W-1:0] addr);
        t_uword w;
        begin
            case (addr)
                A_IDLE:  w = '{in_rdy: 1'b1, jc: JC_ACCEPT, tgt: A_DRAW0, default: '0};
                A_WARM0: w = '{jc: JC_NEXT, default: '0};
                A_WARM1: w = '{jc: JC_NEXT, default: '0};
                A_WARM2: w = '{step_g1: 1'b1, wr_cnt: 1'b1, dec_cnt: 1'b1,
                               jc: JC_LOOP, tgt: A_WARM0, default: '0};
                A_PRIME: w = '{prev_g1: 1'b1, jc: JC_NEXT, default: '0};
                A_DRAW0: w = '{jc: JC_NEXT, default: '0};
                A_DRAW1: w = '{jc: JC_NEXT, default: '0};
                A_DRAW2: w = '{jc: JC_NEXT, default: '0};
                A_DRAW3: w = '{step_g1: 1'b1, step_g2: 1'b1, wr_slot: 1'b1,
                               prev_mix: 1'b1, out_load: 1'b1, wait_out: 1'b1,
                               jc: JC_JUMP, tgt: A_IDLE, default: '0};
                default: w = '{jc: JC_JUMP, tgt: A_IDLE, default: '0};
            endcase
            return w;
        end
    endfunction

endpackage

### hw/rtl/clsrng_useq.sv
`timescale 1ns / 1ps

module clsrng_useq #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_mode,
    input  clsrng_pkg::t_dp_sts               i_sts,
    output logic                              o_ready,
    output clsrng_pkg::t_dp_ctl               o_ctl,
    output logic [$clog2(TABLE_DEPTH)-1:0]    o_wr_idx
);
    import clsrng_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 8);
    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic [PC_W-1:0]  r_pc;
    logic [PC_W-1:0]  n_pc;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    t_uword           cw;
    logic             acc;
    logic             hold;
    logic             in_fill;

    always_comb begin
        cw      = f_urom(r_pc);
        acc     = i_valid & cw.in_rdy;
        hold    = cw.wait_out & i_sts.out_busy;
        in_fill = r_cnt < CNT_W'(TABLE_DEPTH);

        case (cw.jc)
            JC_NEXT:   n_pc = r_pc + 1'b1;
            JC_JUMP:   n_pc = cw.tgt;
            JC_ACCEPT: n_pc = !acc ? r_pc : (i_mode ? r_pc + 1'b1 : cw.tgt);
            JC_LOOP:   n_pc = (r_cnt != '0) ? cw.tgt : r_pc + 1'b1;
            default:   n_pc = A_IDLE;
        endcase
        if (hold) begin
            n_pc = r_pc;
        end

        n_cnt = r_cnt;
        if (acc && i_mode) begin
            n_cnt = CNT_W'(TABLE_DEPTH + 7);
        end else if (cw.dec_cnt) begin
            n_cnt = r_cnt - 1'b1;
        end

        o_ctl.load_seed = acc & i_mode;
        o_ctl.step_g1   = cw.step_g1 & ~hold;
        o_ctl.step_g2   = cw.step_g2 & ~hold;
        o_ctl.wr_en     = (cw.wr_cnt & in_fill) | (cw.wr_slot & ~hold);
        o_ctl.wr_slot   = cw.wr_slot;
        o_ctl.prev_g1   = cw.prev_g1;
        o_ctl.prev_mix  = cw.prev_mix & ~hold;
        o_ctl.out_load  = cw.out_load & ~hold;
    end

    assign o_ready  = cw.in_rdy;
    assign o_wr_idx = r_cnt[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= A_IDLE;
            r_cnt <= '0;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
        end
    end

endmodule

### hw/rtl/clsrng_dpath.sv
`timescale 1ns / 1ps

module clsrng_dpath #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  clsrng_pkg::t_dp_ctl               i_ctl,
    input  logic [$clog2(TABLE_DEPTH)-1:0]    i_wr_idx,
    input  logic [30:0]                       i_seed,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [30:0]                       o_out_value,
    output clsrng_pkg::t_dp_sts               o_sts
);
    import clsrng_pkg::*;

    localparam int          IDX_W    = $clog2(TABLE_DEPTH);
    localparam logic [63:0] SLOT_DIV = 64'((MOD1 - 32'd1) / TABLE_DEPTH) + 64'd1;
    localparam int          SLOT_L   = $clog2(SLOT_DIV);
    localparam logic [63:0] POW      = 64'd1 << (31 + SLOT_L);
    localparam logic [63:0] MAGIC64  = (POW + SLOT_DIV - 64'd1) / SLOT_DIV;
    localparam logic [31:0] MAGIC    = MAGIC64[31:0];
    localparam int          Q_W      = 32 - SLOT_L;

    logic [VAL_W-1:0]  r_g1;
    logic [VAL_W-1:0]  r_g2;
    logic [VAL_W-1:0]  r_prev;
    logic [PROD_W-1:0] r_p1;
    logic [PROD_W-1:0] r_p2;
    logic [31:0]       r_f1;
    logic [31:0]       r_f2;
    logic [62:0]       r_sp;
    logic [IDX_W-1:0]  r_slot;
    logic [VAL_W-1:0]  r_tab [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_vld;
    logic [VAL_W-1:0]  r_rd;
    logic              r_rd_vld;
    logic [VAL_W-1:0]  r_out;
    logic              r_ovld;

    logic [VAL_W-1:0]  seed;
    logic [VAL_W-1:0]  red1;
    logic [VAL_W-1:0]  red2;
    logic [Q_W-1:0]    quo;
    logic [IDX_W-1:0]  slot;
    logic [VAL_W-1:0]  ent;
    logic [31:0]       diff;
    logic [VAL_W-1:0]  mix;
    logic [IDX_W-1:0]  wr_addr;

    always_comb begin
        seed    = (i_seed == '0) ? 31'd1 : i_seed;
        red1    = (r_f1 >= MOD1) ? 31'(r_f1 - MOD1) : r_f1[30:0];
        red2    = (r_f2 >= MOD2) ? 31'(r_f2 - MOD2) : r_f2[30:0];
        quo     = r_sp[62 -: Q_W];
        slot    = (32'(quo) > 32'(TABLE_DEPTH - 1)) ? IDX_W'(TABLE_DEPTH - 1)
                                                    : IDX_W'(quo);
        ent     = r_rd_vld ? r_rd : '0;
        diff    = {1'b0, ent} - {1'b0, red2};
        mix     = (diff[31] || diff == '0) ? 31'(diff + WRAP_TOP) : diff[30:0];
        wr_addr = i_ctl.wr_slot ? r_slot : i_wr_idx;
    end

    always_ff @(posedge i_clk) begin
        r_p1   <= PROD_W'(r_g1) * PROD_W'(MUL1);
        r_p2   <= PROD_W'(r_g2) * PROD_W'(MUL2);
        r_f1   <= 32'(r_p1[PROD_W-1:VAL_W]) * 32'(FOLD1) + 32'(r_p1[VAL_W-1:0]);
        r_f2   <= 32'(r_p2[PROD_W-1:VAL_W]) * 32'(FOLD2) + 32'(r_p2[VAL_W-1:0]);
        r_sp   <= 63'(r_prev) * 63'(MAGIC);
        r_slot <= slot;
        r_rd     <= r_tab[r_slot];
        r_rd_vld <= r_vld[r_slot];
        if (i_ctl.wr_en) begin
            r_tab[wr_addr] <= red1;
        end
        if (i_ctl.out_load) begin
            r_out <= mix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g1   <= G1_RESET;
            r_g2   <= G2_RESET;
            r_prev <= '0;
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (i_ctl.load_seed) begin
                r_g1 <= seed;
                r_g2 <= seed;
            end else begin
                if (i_ctl.step_g1) begin
                    r_g1 <= red1;
                end
                if (i_ctl.step_g2) begin
                    r_g2 <= red2;
                end
            end
            if (i_ctl.prev_g1) begin
                r_prev <= r_g1;
            end else if (i_ctl.prev_mix) begin
                r_prev <= mix;
            end
            if (i_ctl.wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_ctl.out_load) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_ovld;
    assign o_out_value    = r_out;
    assign o_sts.out_busy = r_ovld & ~i_out_ready;

endmodule

### hw/rtl/combined_lcg_shuffle_rng.sv
`timescale 1ns / 1ps

// Combined two-generator multiplicative random source with a shuffle table. Each input beat
// either draws (tuser 0) or reseeds from tdata and then draws (tuser 1); every beat yields one
// output beat with a value in 1..2147483562, to be divided by 2147483563 downstream for a
// uniform fraction. On a draw the sequencer waits out the registered multiply, modular fold
// and table read before the final swap step, and takes no new beat until it is done. A reseed
// runs the first generator through TABLE_DEPTH+8 warm-up steps, each through the same
// registered multiply, fold and reduce path. One finished result waits in the output register;
// the sequencer stalls on its last step only while that register is still occupied. The table
// reads as all zeros after reset through per-entry valid bits, no clearing pass.
module combined_lcg_shuffle_rng #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [30:0] seed_value, [31] zero
    input  logic        i_s_tuser,   // [0] mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [30:0] random_value, [31] zero
);
    import clsrng_pkg::*;

    t_dp_ctl                          ctl;
    t_dp_sts                          sts;
    logic [$clog2(TABLE_DEPTH)-1:0]   wr_idx;
    logic [VAL_W-1:0]                 out_value;

    clsrng_useq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_mode   (i_s_tuser),
        .i_sts    (sts),
        .o_ready  (o_s_tready),
        .o_ctl    (ctl),
        .o_wr_idx (wr_idx)
    );

    clsrng_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_wr_idx    (wr_idx),
        .i_seed      (i_s_tdata[30:0]),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_value (out_value),
        .o_sts       (sts)
    );

    assign o_m_tdata = {1'b0, out_value};

endmodule

### hw/rtl/clsrng_chk.sv
`timescale 1ns / 1ps

module clsrng_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [31:0] i_s_tdata,
    input logic        i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);

    logic in_beat;

    assign in_beat = i_s_tvalid & o_s_tready;

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[30:0] != 31'd0) && (o_m_tdata[30:0] <= 31'd2147483562)
                       && (o_m_tdata[31] == 1'b0))
        else $error("output value out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled output beat changed");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !o_s_tready)
        else $error("input taken while a beat is in work");

    a_draw_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && !i_s_tuser |-> ##5 o_m_tvalid)
        else $error("draw beat produced no output");

    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && !i_s_tuser |-> ##4 !o_s_tready)
        else $error("input reopened before draw finished");

endmodule

bind combined_lcg_shuffle_rng clsrng_chk u_chk (.*);
